// ===== hw/rtl/avfdu_pkg.sv =====
package avfdu_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_ENTRY    = 2'd0;
    localparam logic [1:0] STATUS_NOFIT    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam int NUM_LAYOUTS = 4;

    // Layout bits: 32-bit little, 64-bit little, 32-bit big, 64-bit big.
    localparam logic [NUM_LAYOUTS-1:0] LAY_W8  = 4'b1010;
    localparam logic [NUM_LAYOUTS-1:0] LAY_BIG = 4'b1100;

    localparam logic [3:0] WORD_BYTES_4 = 4'd4;
    localparam logic [3:0] WORD_BYTES_8 = 4'd8;

    localparam int TYPE_W = 16;
    localparam logic [TYPE_W-1:0] MAX_TYPE_RESET = 16'd1024;

    // Control from the top level to the layout checker.
    typedef struct packed {
        logic       upd;   // a byte is stored at position pos
        logic       clr;   // end of vector, clear all flags
        logic [3:0] pos;   // low bits of the byte position
    } trk_ctl_t;

endpackage

// ===== hw/rtl/avfdu_ram.sv =====
module avfdu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/avfdu_track.sv =====
module avfdu_track (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  avfdu_pkg::trk_ctl_t                      ctl,
    input  logic [7:0]                               data,
    input  logic [avfdu_pkg::TYPE_W-1:0]             max_type,
    output logic [avfdu_pkg::NUM_LAYOUTS-1:0]        failed
);

    // Per layout, the type word is kept as its low 16 bits plus a flag that
    // some higher byte was nonzero; that is all the compare and zero test need.
    logic [avfdu_pkg::TYPE_W-1:0]      lo_reg   [avfdu_pkg::NUM_LAYOUTS];
    logic [avfdu_pkg::TYPE_W-1:0]      lo_next  [avfdu_pkg::NUM_LAYOUTS];
    logic [avfdu_pkg::NUM_LAYOUTS-1:0] hi_reg, hi_next;
    logic [avfdu_pkg::NUM_LAYOUTS-1:0] zero_reg, zero_next;
    logic [avfdu_pkg::NUM_LAYOUTS-1:0] failed_reg, failed_next;

    always_comb begin
        logic                         w8;
        logic                         in_type;
        logic [2:0]                   k;
        logic                         done;
        logic [avfdu_pkg::TYPE_W-1:0] base_lo;
        logic                         base_hi;
        logic [avfdu_pkg::TYPE_W-1:0] lo_n;
        logic                         hi_n;
        for (int i = 0; i < avfdu_pkg::NUM_LAYOUTS; i++) begin
            w8      = avfdu_pkg::LAY_W8[i];
            in_type = w8 ? ~ctl.pos[3] : ~ctl.pos[2];
            k       = w8 ? ctl.pos[2:0] : {1'b0, ctl.pos[1:0]};
            done    = w8 ? (k == 3'd7) : (k == 3'd3);
            base_lo = (k == 3'd0) ? '0 : lo_reg[i];
            base_hi = (k == 3'd0) ? 1'b0 : hi_reg[i];
            if (avfdu_pkg::LAY_BIG[i]) begin
                hi_n = base_hi | (base_lo[15:8] != 8'h00);
                lo_n = {base_lo[7:0], data};
            end else begin
                unique case (k)
                    3'd0: begin
                        lo_n = {8'h00, data};
                        hi_n = 1'b0;
                    end
                    3'd1: begin
                        lo_n = {data, base_lo[7:0]};
                        hi_n = base_hi;
                    end
                    default: begin
                        lo_n = base_lo;
                        hi_n = base_hi | (data != 8'h00);
                    end
                endcase
            end

            lo_next[i]     = lo_reg[i];
            hi_next[i]     = hi_reg[i];
            zero_next[i]   = zero_reg[i];
            failed_next[i] = failed_reg[i];
            if (ctl.clr) begin
                hi_next[i]     = 1'b0;
                zero_next[i]   = 1'b0;
                failed_next[i] = 1'b0;
            end else if (ctl.upd && in_type) begin
                lo_next[i] = lo_n;
                hi_next[i] = hi_n;
                if (done) begin
                    // A zero type is allowed only as the final entry.
                    failed_next[i] = failed_reg[i] | zero_reg[i] | hi_n | (lo_n > max_type);
                    zero_next[i]   = ~hi_n & (lo_n == '0);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg     <= '0;
            zero_reg   <= '0;
            failed_reg <= '0;
        end else begin
            hi_reg     <= hi_next;
            zero_reg   <= zero_next;
            failed_reg <= failed_next;
        end
        for (int i = 0; i < avfdu_pkg::NUM_LAYOUTS; i++) begin
            lo_reg[i] <= lo_next[i];
        end
    end

    assign failed = failed_reg;

endmodule

// ===== hw/rtl/aux_vector_format_detect_unpack.sv =====
// Channel   Dir  Payload                                              Handshake
// s_        in   tdata: data_byte; tlast: last_byte                   tvalid/tready
// m_        out  tdata: mask..value; tuser: status; tlast: last_result tvalid/tready
// cfg_      in   max_type, written when cfg_wen is high               none
//
// Bytes load at one per cycle into the byte store. The final byte is followed by
// a decision state; then each entry of 2*W bytes is read back from the store at
// one byte per cycle through its registered read port, and the entry is handed
// to the output register. Reset is synchronous and active low; the store needs
// no clearing after reset. A stalled output holds the replay; new bytes are taken
// once the last result of a vector sits in the output register.
module aux_vector_format_detect_unpack #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,     // [7:0] data_byte
    input  logic          s_tlast,     // last_byte

    output logic          m_tvalid,
    input  logic          m_tready,
    // [3:0] fit_mask, [7:4] word_bytes, [8] big_endian, [15:9] entry_count,
    // [21:16] entry_index, [37:22] entry_type, [101:38] entry_value, [103:102] zero
    output logic [103:0]  m_tdata,
    output logic [1:0]    m_tuser,     // [1:0] status
    output logic          m_tlast,     // last_result

    input  logic          cfg_wen,
    input  logic [15:0]   cfg_wdata    // [15:0] max_type
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DECIDE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t         state_reg;
    logic [15:0]    max_type_reg;
    logic [CW-1:0]  count_reg;
    logic           ovf_reg;
    logic           sel_w8_reg;
    logic           sel_big_reg;
    logic [CW-1:0]  rd_addr_reg;
    logic [4:0]     iss_reg;
    logic [3:0]     got_reg;
    logic           rd_vld_reg;
    logic [5:0]     idx_reg;
    logic [63:0]    type_sr_reg;
    logic [63:0]    val_sr_reg;

    logic           m_tvalid_reg;
    logic [1:0]     status_reg;
    logic [3:0]     mask_reg;
    logic [3:0]     wb_reg;
    logic           big_reg;
    logic [6:0]     cnt_reg;
    logic [5:0]     oidx_reg;
    logic [15:0]    otype_reg;
    logic [63:0]    oval_reg;
    logic           olast_reg;

    logic                                in_acc;
    logic                                has_room;
    logic                                out_free;
    logic                                out_load;
    logic [avfdu_pkg::NUM_LAYOUTS-1:0]   failed;
    logic [avfdu_pkg::NUM_LAYOUTS-1:0]   fit;
    logic                                fit_one;
    logic                                err_now;
    logic                                clr;
    logic [4:0]                          lim;
    logic                                rd_en;
    logic [7:0]                          rd_data;
    logic                                last_entry;
    logic [CW-1:0]                       n_full;
    logic [63:0]                         type_word;
    logic [63:0]                         val_word;
    avfdu_pkg::trk_ctl_t                 trk_ctl;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_acc   = s_tvalid & s_tready;
    assign has_room = (count_reg < CW'(BUFFER_BYTES));
    assign out_free = ~m_tvalid_reg | m_tready;

    // A 32-bit layout needs a multiple of 8 bytes, a 64-bit one of 16.
    assign fit[0]  = ~failed[0] & (count_reg[2:0] == 3'd0);
    assign fit[1]  = ~failed[1] & (count_reg[3:0] == 4'd0);
    assign fit[2]  = ~failed[2] & (count_reg[2:0] == 3'd0);
    assign fit[3]  = ~failed[3] & (count_reg[3:0] == 4'd0);
    assign fit_one = ($countones(fit) == 1);
    assign err_now = ovf_reg | ~fit_one;

    assign lim        = sel_w8_reg ? 5'd16 : 5'd8;
    assign rd_en      = (state_reg == ST_READ) && (iss_reg != lim);
    assign last_entry = (rd_addr_reg == count_reg);
    assign n_full     = sel_w8_reg ? (count_reg >> 4) : (count_reg >> 3);

    // Little-endian 32-bit words fill the top half of the shift register.
    assign type_word = (!sel_big_reg && !sel_w8_reg) ? (type_sr_reg >> 32) : type_sr_reg;
    assign val_word  = (!sel_big_reg && !sel_w8_reg) ? (val_sr_reg >> 32)  : val_sr_reg;

    // The output register takes a new transaction in these two cases.
    assign out_load = ((state_reg == ST_DECIDE) && err_now && out_free)
                    || ((state_reg == ST_EMIT) && out_free);

    assign clr = ((state_reg == ST_DECIDE) && err_now && out_free)
               || ((state_reg == ST_EMIT) && out_free && last_entry);

    assign trk_ctl.upd = in_acc & has_room;
    assign trk_ctl.clr = clr;
    assign trk_ctl.pos = count_reg[3:0];

    avfdu_track u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (trk_ctl),
        .data     (s_tdata),
        .max_type (max_type_reg),
        .failed   (failed)
    );

    avfdu_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (in_acc & has_room),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata),
        .re    (rd_en),
        .raddr (rd_addr_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            max_type_reg <= avfdu_pkg::MAX_TYPE_RESET;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                max_type_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            rd_vld_reg <= rd_en;
            if (rd_en) begin
                rd_addr_reg <= rd_addr_reg + CW'(1);
                iss_reg     <= iss_reg + 5'd1;
            end

            unique case (state_reg)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (has_room) begin
                            count_reg <= count_reg + CW'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    if (err_now) begin
                        if (out_free) begin
                            status_reg   <= ovf_reg ? avfdu_pkg::STATUS_OVERFLOW
                                                    : avfdu_pkg::STATUS_NOFIT;
                            mask_reg     <= ovf_reg ? 4'd0 : fit;
                            wb_reg       <= '0;
                            big_reg      <= 1'b0;
                            cnt_reg      <= '0;
                            oidx_reg     <= '0;
                            otype_reg    <= '0;
                            oval_reg     <= '0;
                            olast_reg    <= 1'b1;
                            count_reg    <= '0;
                            ovf_reg      <= 1'b0;
                            state_reg    <= ST_LOAD;
                        end
                    end else begin
                        sel_w8_reg  <= fit[1] | fit[3];
                        sel_big_reg <= fit[2] | fit[3];
                        rd_addr_reg <= '0;
                        iss_reg     <= '0;
                        got_reg     <= '0;
                        idx_reg     <= '0;
                        type_sr_reg <= '0;
                        val_sr_reg  <= '0;
                        state_reg   <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (rd_vld_reg) begin
                        // The first word of the entry is the type, the second the value.
                        if (sel_w8_reg ? ~got_reg[3] : ~got_reg[2]) begin
                            type_sr_reg <= sel_big_reg ? {type_sr_reg[55:0], rd_data}
                                                       : {rd_data, type_sr_reg[63:8]};
                        end else begin
                            val_sr_reg <= sel_big_reg ? {val_sr_reg[55:0], rd_data}
                                                      : {rd_data, val_sr_reg[63:8]};
                        end
                        got_reg <= got_reg + 4'd1;
                        if ({1'b0, got_reg} == lim - 5'd1) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        status_reg   <= avfdu_pkg::STATUS_ENTRY;
                        mask_reg     <= fit;
                        wb_reg       <= sel_w8_reg ? avfdu_pkg::WORD_BYTES_8
                                                   : avfdu_pkg::WORD_BYTES_4;
                        big_reg      <= sel_big_reg;
                        cnt_reg      <= 7'(n_full);
                        oidx_reg     <= idx_reg;
                        otype_reg    <= type_word[15:0];
                        oval_reg     <= val_word;
                        olast_reg    <= last_entry;
                        idx_reg      <= idx_reg + 6'd1;
                        if (last_entry) begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end else begin
                            iss_reg     <= '0;
                            got_reg     <= '0;
                            type_sr_reg <= '0;
                            val_sr_reg  <= '0;
                            state_reg   <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, oval_reg, otype_reg, oidx_reg, cnt_reg, big_reg, wb_reg, mask_reg};

endmodule
